// ----- rtl/spe_pkg.sv -----
package spe_pkg;

	localparam int unsigned SLOTS_DEF = 32;

	typedef enum logic [1:0] {
		OP_SPAWN = 2'd0,
		OP_TICK  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic KIND_SPRITE = 1'b0;
	localparam logic KIND_TILE   = 1'b1;

	localparam int signed SCR_MIN   = -8;
	localparam int signed SCR_X_MAX = 240;
	localparam int signed SCR_Y_MAX = 160;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [11:0] start_frame;
		logic [3:0]  anim_count;
		logic [7:0]  life;
		logic [1:0]  prio;
		logic [1:0]  flip;
		logic [3:0]  palette;
		logic [1:0]  gravity;
		logic [15:0] random_bits;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [4:0]  slot;
		logic [15:0] frame_offset;
		logic [8:0]  screen_x;
		logic [7:0]  screen_y;
		logic [3:0]  out_palette;
		logic [1:0]  out_prio;
		logic [1:0]  out_flip;
		logic        last;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch input item
		logic spawn;     // write spawn slot
		logic clear;     // clear sweep step at index
		logic rd;        // issue read of slot at index
		logic proc;      // process read data for slot
		logic idx_rst;
		logic idx_inc;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       spawn_ok;
		logic       idx_end;
		logic       out_busy;
		logic [1:0] op;
	} dp_sts_t;

	// (b & 0x7F) / 5, inverted when bit 7 is set
	function automatic logic [7:0] rand_vel(input logic [7:0] b);
		logic [7:0] v;
		logic [14:0] p;
		begin
			// x/5 for x<128 : (x*205)>>10
			p = {8'd0, b[6:0]} * 15'd205;
			v = {3'd0, p[14:10]};
			rand_vel = b[7] ? ~v : v;
		end
	endfunction

endpackage

// ----- rtl/spe_if.sv -----
interface spe_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/spe_ctrl.sv -----
module spe_ctrl
	import spe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DEC   = 6'b000010,
		ST_RD    = 6'b000100,
		ST_PROC  = 6'b001000,
		ST_CLR   = 6'b010000,
		ST_DRAIN = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DEC;
				end
			end
			ST_DEC: begin
				cmd.idx_rst = 1'b1;
				case (sts.op)
					OP_SPAWN: begin
						if (!sts.spawn_ok) state_d = ST_IDLE;
						else if (!sts.out_busy) begin
							cmd.spawn = 1'b1;
							state_d   = ST_DRAIN;
						end
					end
					OP_TICK:  state_d = ST_RD;
					OP_CLEAR: state_d = ST_CLR;
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_PROC;
			end
			ST_PROC: begin
				// wait until the output register is free for up to two items
				if (!sts.out_busy) begin
					cmd.proc    = 1'b1;
					cmd.idx_inc = 1'b1;
					state_d     = sts.idx_end ? ST_DRAIN : ST_RD;
				end
			end
			ST_CLR: begin
				cmd.clear   = 1'b1;
				cmd.idx_inc = 1'b1;
				if (sts.idx_end) state_d = ST_IDLE;
			end
			ST_DRAIN: begin
				if (!sts.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	a_proc_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.proc |-> !sts.out_busy) else $error("proc while output busy");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE) else $error("load outside idle");
	a_rd_proc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |=> state_q == ST_PROC) else $error("read not followed by proc");
endmodule

// ----- rtl/spe_dp.sv -----
module spe_dp
	import spe_pkg::*;
#(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t in_data,
	input  dp_cmd_t  cmd,
	output dp_sts_t  sts,
	output logic     out_valid,
	input  logic     out_ready,
	output out_item_t out_data
);
	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	in_item_t itm_q;
	logic [31:0] xmem [SLOTS];
	logic [31:0] ymem [SLOTS];
	logic [31:0] lmem [SLOTS];
	logic [SLOTS-1:0] vld_q; // x/y entries valid (else zero)
	logic [SLOTS-1:0] lvld_q;
	logic [IW-1:0] idx_q, next_q;
	logic [31:0] xr_s1, yr_s1, lk_s1;
	logic xv_s1, lv_s1;

	// two-entry output queue
	out_item_t oq_q [2];
	logic [1:0] ocnt_q;
	logic       any_q; // a non-final slot of this run already processed

	assign sts.op       = itm_q.opcode;
	assign sts.spawn_ok = (itm_q.life != 8'd0) &&
		!((itm_q.start_frame == 12'd0) && (itm_q.anim_count == 4'd0));
	assign sts.idx_end  = ({1'b0, idx_q} == (IW+1)'(SLOTS - 1));
	assign sts.out_busy = (ocnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (cmd.load) itm_q <= in_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			xr_s1 <= xmem[idx_q];
			yr_s1 <= ymem[idx_q];
			lk_s1 <= lmem[idx_q];
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xv_s1 <= 1'b0;
			lv_s1 <= 1'b0;
		end else if (cmd.rd) begin
			xv_s1 <= vld_q[idx_q];
			lv_s1 <= lvld_q[idx_q];
		end
	end

	// tick arithmetic
	logic [31:0] xr, yr, lk, xn, yn;
	logic        dead, reload, xkill, ykill;
	logic [15:0] px, py;
	logic signed [13:0] sx, sy;
	logic [8:0]  vel; // one bit wider than the stored field, so the move sees the true sum
	logic [1:0]  g;
	logic [15:0] fo_t;
	logic [31:0] yadj;

	always_comb begin
		xr = xv_s1 ? xr_s1 : 32'd0;
		yr = xv_s1 ? yr_s1 : 32'd0;
		lk = lv_s1 ? lk_s1 : 32'd0;
		dead   = (xr[31:24] == 8'd0);
		reload = dead && (yr[31:28] != 4'd0);
		yadj = reload ? (yr - 32'h1000_0000) : yr;
		xn = xr;
		if (reload) xn[31:24] = lk[31:24];
		xn[31:24] = xn[31:24] - 8'd1;
		px = xn[15:0] + {{8{xn[23]}}, xn[23:16]};
		xn[15:0] = px;
		sx = $signed({2'b00, px[15:4]}) - $signed({2'b00, itm_q.pos_x});
		xkill = (sx < 14'(SCR_MIN)) || (sx > 14'(SCR_X_MAX));
		g = lk[17:16];
		case (g)
			2'd0:    vel = {yadj[23], yadj[23:16]} + 9'd1;
			2'd1:    vel = {yadj[23], yadj[23:16]} + 9'd2;
			2'd2:    vel = {yadj[23], yadj[23:16]} - 9'd1;
			default: vel = {yadj[23], yadj[23:16]};
		endcase
		py = yadj[15:0] + {{7{vel[8]}}, vel};
		sy = $signed({2'b00, py[15:4]}) - $signed({2'b00, itm_q.pos_y});
		ykill = (sy < 14'(SCR_MIN)) || (sy > 14'(SCR_Y_MAX));
		yn = {yadj[31:24], vel[7:0], py};
		fo_t = 16'({4'd0, yadj[31:28]} + {4'd0, lk[11:0]}) << 3;
	end

	// spawn records
	logic [31:0] sxr, syr, slk;
	logic [15:0] sfo;
	always_comb begin
		sxr = {itm_q.life, rand_vel(itm_q.random_bits[7:0]), itm_q.pos_x, 4'd0};
		syr = {itm_q.anim_count, itm_q.palette, rand_vel(itm_q.random_bits[15:8]),
			itm_q.pos_y, 4'd0};
		slk = {itm_q.life, 6'd0, itm_q.gravity, itm_q.prio, itm_q.flip, itm_q.start_frame};
		sfo = 16'({4'd0, itm_q.anim_count} + {4'd0, itm_q.start_frame}) << 3;
	end

	logic do_tick;
	assign do_tick = cmd.proc && !(dead && !reload);

	always_ff @(posedge clk) begin
		if (cmd.spawn) begin
			xmem[next_q] <= sxr;
			ymem[next_q] <= syr;
			lmem[next_q] <= slk;
		end else if (do_tick) begin
			xmem[idx_q] <= (xkill || ykill) ? {8'd0, xn[23:0]} : xn;
			ymem[idx_q] <= xkill ? yadj : yn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			lvld_q <= '0;
			next_q <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.spawn) begin
				vld_q[next_q]  <= 1'b1;
				lvld_q[next_q] <= 1'b1;
				next_q <= ({1'b0, next_q} == (IW+1)'(SLOTS - 1)) ? '0 : next_q + 1'b1;
			end else if (do_tick) vld_q[idx_q] <= 1'b1;
			if (cmd.clear) vld_q[idx_q] <= 1'b0;
			if (cmd.idx_rst) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= sts.idx_end ? '0 : idx_q + 1'b1;
		end
	end

	// result generation: tile then sprite for one slot
	out_item_t tile_i, spr_i;
	logic t_en, s_en;
	logic [4:0] slot5;
	assign slot5 = 5'(idx_q);
	always_comb begin
		tile_i = '0;
		tile_i.kind = KIND_TILE;
		tile_i.slot = cmd.spawn ? 5'(next_q) : slot5;
		tile_i.frame_offset = cmd.spawn ? sfo : fo_t;
		tile_i.last = cmd.spawn || (sts.idx_end && !s_en);
		spr_i = '0;
		spr_i.kind = KIND_SPRITE;
		spr_i.slot = slot5;
		spr_i.screen_x = sx[8:0];
		spr_i.screen_y = sy[7:0];
		spr_i.out_palette = yn[27:24];
		spr_i.out_prio = lk[15:14];
		spr_i.out_flip = lk[13:12];
		spr_i.last = sts.idx_end;
		t_en = cmd.spawn || (cmd.proc && reload);
		s_en = do_tick && !xkill && !ykill;
	end

	// "last" must land on the final result of a run; pending item holds
	// until we know whether another follows (a held-back lag item).
	out_item_t hold_q;
	out_item_t hold_last;
	logic hold_v_q;
	logic fin;
	assign fin = cmd.spawn || (cmd.proc && sts.idx_end);

	always_comb begin
		hold_last = hold_q;
		hold_last.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_q[0]  <= '0;
			oq_q[1]  <= '0;
			hold_q   <= '0;
			ocnt_q   <= '0;
			hold_v_q <= 1'b0;
			any_q    <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				oq_q[0] <= oq_q[1];
				ocnt_q  <= ocnt_q - 2'd1;
			end
			if (cmd.proc || cmd.spawn) begin
				// gather new items in order: held, tile, sprite
				if (fin) begin
					// final slot; with three items, held+tile go now and sprite stays held
					hold_v_q <= hold_v_q && t_en && s_en;
					if (s_en) begin
						if (hold_v_q && t_en) begin
							oq_q[0] <= hold_q;
							oq_q[1] <= tile_i;
							hold_q  <= spr_i;
							ocnt_q  <= 2'd2;
						end else begin
							oq_q[0] <= hold_v_q ? hold_q : (t_en ? tile_i : spr_i);
							oq_q[1] <= spr_i;
							ocnt_q  <= ((hold_v_q || t_en) ? 2'd2 : 2'd1);
						end
					end else if (t_en) begin
						oq_q[0] <= hold_v_q ? hold_q : tile_i;
						oq_q[1] <= tile_i;
						ocnt_q  <= hold_v_q ? 2'd2 : 2'd1;
					end else if (hold_v_q) begin
						oq_q[0] <= hold_last;
						ocnt_q  <= 2'd1;
					end
				end else begin
					// not final: newest item held, earlier ones released
					if (t_en && s_en) begin
						oq_q[0] <= hold_v_q ? hold_q : tile_i;
						oq_q[1] <= tile_i;
						ocnt_q  <= hold_v_q ? 2'd2 : 2'd1;
						hold_q  <= spr_i;
						hold_v_q <= 1'b1;
					end else if (t_en || s_en) begin
						if (hold_v_q) begin
							oq_q[0] <= hold_q;
							ocnt_q  <= 2'd1;
						end
						hold_q  <= t_en ? tile_i : spr_i;
						hold_v_q <= 1'b1;
					end
				end
				any_q <= !fin;
			end else if (hold_v_q && !cmd.proc && ocnt_q == 2'd0 && !any_q) begin
				// pending sprite from a three-item final slot
				oq_q[0]  <= hold_q;
				ocnt_q   <= 2'd1;
				hold_v_q <= 1'b0;
			end
		end
	end

	assign out_valid = (ocnt_q != 2'd0);
	assign out_data  = oq_q[0];

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3) else $error("queue overflow");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.proc || cmd.spawn) |-> ocnt_q == 2'd0) else $error("write into busy queue");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.spawn && cmd.proc)) else $error("spawn and tick together");
endmodule

// ----- rtl/sprite_particle_engine_core.sv -----
// Particle sprite engine. Keeps SLOTS particle records in on-chip memories
// (x, y and look words, one read port each). Opcode 0 spawns into the next
// ring slot and returns one tile load item; 1 ticks every slot, returning a
// tile load item for each frame step and a sprite attribute item for each
// visible particle, the final item of the run marked with last; 2 clears all
// slots and returns nothing. A spawn writes the slot records; a tick reads
// each slot (memory read then update), waiting while the output side
// stalls; a clear sweeps the valid bits, one slot a cycle. One item is in
// flight at a time.
module sprite_particle_engine_core
	import spe_pkg::*;
#(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	spe_if.sink   in_ch,
	spe_if.source out_ch
);
	dp_cmd_t cmd;
	dp_sts_t sts;

	// controller: sequences spawn, the slot walk of a tick, and clear
	spe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: slot memories, update arithmetic, output queue
	spe_dp #(.SLOTS(SLOTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_ch.data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_data  (out_ch.data)
	);
endmodule
